// ===== src/rarm_pkg.sv =====
// Package with shared constants, controller states and the command and status structs.
`default_nettype none
package rarm_pkg;

  // Default sizes and the fixed field widths of the ports.
  localparam int NUM_ELEMENTS_DEF = 1024;
  localparam int VALUE_WIDTH_DEF  = 48;
  localparam int IDX_W            = 11;
  localparam int DELTA_W          = 32;
  localparam int OUT_W            = 47;
  localparam int SIZE_RESET       = 1024;

  // Request modes.
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Stack frame phases.
  localparam logic PHASE_LEFT  = 1'b0;
  localparam logic PHASE_RIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_LOAD,
    ST_APPLY1,
    ST_APPLY2,
    ST_APPLY3,
    ST_DECIDE,
    ST_RETURN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_wr;
    logic clr_step;
    logic accept;
    logic visit_rd;
    logic load;
    logic amt_v;
    logic apply1;
    logic apply2;
    logic apply3;
    logic acc_upd;
    logic ret_nm;
    logic ret_zero;
    logic descend;
    logic ret_right;
    logic ret_up;
    logic emit;
    logic in_ready;
    logic cfg_ready;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic disjoint;
    logic full;
    logic has_child;
    logic tn_child;
    logic amt_zero;
    logic sp_zero;
    logic top_phase;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== src/rarm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module rarm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/rarm_ctrl.sv =====
// Controller state machine that sequences the tree walk, node pushes and clearing pass.
`default_nettype none
module rarm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              cfg_valid,
  input  wire rarm_pkg::status_t status,
  output rarm_pkg::cmd_t         cmd
);
  import rarm_pkg::*;

  state_t state;
  state_t state_next;
  logic   second;
  logic   second_next;
  logic   in_ready;
  logic   cfg_ready;
  logic   in_acc;
  logic   cfg_acc;

  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE) || (state == ST_CLEAR);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  // Next state.
  always_comb begin
    state_next  = state;
    second_next = second;
    case (state)
      ST_CLEAR: begin
        if (!cfg_acc && status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_acc) begin
          state_next = ST_CLEAR;
        end else if (in_acc) begin
          state_next = ST_VISIT;
        end
      end
      ST_VISIT: begin
        second_next = 1'b0;
        if (status.is_query && status.disjoint) begin
          state_next = ST_RETURN;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_APPLY1;
      end
      ST_APPLY1: begin
        if (status.amt_zero || !status.has_child) begin
          state_next = ST_DECIDE;
        end else begin
          state_next = ST_APPLY2;
        end
      end
      ST_APPLY2: begin
        state_next = ST_APPLY3;
      end
      ST_APPLY3: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.is_query) begin
          if (!status.full && status.tn_child) begin
            state_next = ST_VISIT;
          end else begin
            state_next = ST_RETURN;
          end
        end else if (status.disjoint) begin
          state_next = ST_RETURN;
        end else if (status.full) begin
          if (!second) begin
            second_next = 1'b1;
            state_next  = ST_APPLY1;
          end else begin
            state_next = ST_RETURN;
          end
        end else if (status.tn_child) begin
          state_next = ST_VISIT;
        end else begin
          state_next = ST_RETURN;
        end
      end
      ST_RETURN: begin
        if (status.sp_zero) begin
          state_next = ST_DONE;
        end else if (status.top_phase == PHASE_LEFT) begin
          state_next = ST_VISIT;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd.in_ready  = in_ready;
    cmd.cfg_ready = cfg_ready;
    cmd.cfg_wr    = cfg_acc;
    cmd.clr_step  = 1'b0;
    cmd.accept    = 1'b0;
    cmd.visit_rd  = 1'b0;
    cmd.load      = 1'b0;
    cmd.amt_v     = 1'b0;
    cmd.apply1    = 1'b0;
    cmd.apply2    = 1'b0;
    cmd.apply3    = 1'b0;
    cmd.acc_upd   = 1'b0;
    cmd.ret_nm    = 1'b0;
    cmd.ret_zero  = 1'b0;
    cmd.descend   = 1'b0;
    cmd.ret_right = 1'b0;
    cmd.ret_up    = 1'b0;
    cmd.emit      = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = !cfg_acc;
      end
      ST_IDLE: begin
        cmd.accept = in_acc && !cfg_acc;
      end
      ST_VISIT: begin
        if (status.is_query && status.disjoint) begin
          cmd.ret_zero = 1'b1;
        end else begin
          cmd.visit_rd = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ST_APPLY1: begin
        cmd.apply1 = !status.amt_zero;
      end
      ST_APPLY2: begin
        cmd.apply2 = 1'b1;
      end
      ST_APPLY3: begin
        cmd.apply3 = 1'b1;
      end
      ST_DECIDE: begin
        if (status.is_query) begin
          if (status.full) begin
            cmd.acc_upd = 1'b1;
          end else if (status.tn_child) begin
            cmd.descend = 1'b1;
          end
        end else if (status.disjoint) begin
          cmd.ret_nm = 1'b1;
        end else if (status.full) begin
          if (!second) begin
            cmd.amt_v = 1'b1;
          end else begin
            cmd.ret_nm = 1'b1;
          end
        end else if (status.tn_child) begin
          cmd.descend = 1'b1;
        end else begin
          cmd.ret_nm = 1'b1;
        end
      end
      ST_RETURN: begin
        if (!status.sp_zero) begin
          if (status.top_phase == PHASE_LEFT) begin
            cmd.ret_right = 1'b1;
          end else begin
            cmd.ret_up = 1'b1;
          end
        end
      end
      ST_DONE: begin
        cmd.emit = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/rarm_dp.sv =====
// Datapath with the node memories, traversal stack, saturating adders and result register.
`default_nettype none
module rarm_dp #(
  parameter int NUM_ELEMENTS = rarm_pkg::NUM_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = rarm_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rarm_pkg::cmd_t                cmd,
  output rarm_pkg::status_t                  status,
  input  wire logic [rarm_pkg::IDX_W-1:0]    cfg_data,
  input  wire logic                          mode,
  input  wire logic [rarm_pkg::IDX_W-1:0]    range_start,
  input  wire logic [rarm_pkg::IDX_W-1:0]    range_end,
  input  wire logic signed [rarm_pkg::DELTA_W-1:0] delta,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rarm_pkg::OUT_W-1:0]         range_max
);
  import rarm_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int TN    = 4 * NUM_ELEMENTS;
  localparam int KW    = $clog2(TN);
  localparam int IW    = $clog2(NUM_ELEMENTS + 1);
  localparam int CW    = (IW > IDX_W) ? IW : IDX_W;
  localparam int SD    = $clog2(NUM_ELEMENTS) + 1;
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);
  localparam logic [IW-1:0] SIZE_RST =
    IW'((NUM_ELEMENTS < SIZE_RESET) ? NUM_ELEMENTS : SIZE_RESET);
  localparam logic signed [63:0] VMAX64 = signed'((64'd1 << (VW - 1)) - 64'd1);
  localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;

  // Saturating add at the value width.
  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] x,
                                                   input logic signed [VW-1:0] y);
    logic signed [VW:0] sum;
    sum = {x[VW-1], x} + {y[VW-1], y};
    if (sum[VW] != sum[VW-1]) begin
      sat_add = sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      sat_add = sum[VW-1:0];
    end
  endfunction

  // Request and traversal registers.
  logic                   mode_q;
  logic [IDX_W-1:0]       a_q;
  logic [IDX_W-1:0]       b_q;
  logic signed [VW-1:0]   v_q;
  logic [IW-1:0]          size;
  logic [KW-1:0]          clr_cnt;
  logic [KW-1:0]          k;
  logic [IW-1:0]          s;
  logic [IW-1:0]          e;
  logic signed [VW-1:0]   nm;
  logic signed [VW-1:0]   amt;
  logic signed [VW-1:0]   ret;
  logic signed [VW-1:0]   acc;
  logic [SPW-1:0]         sp;

  // Traversal stack, read only at its top.
  logic [KW-1:0]          stk_k     [SD];
  logic [IW-1:0]          stk_s     [SD];
  logic [IW-1:0]          stk_e     [SD];
  logic                   stk_phase [SD];
  logic signed [VW-1:0]   stk_left  [SD];

  logic [SPW-1:0]         sp_m1;
  logic [SIW-1:0]         top;
  logic [KW-1:0]          top_k;
  logic [IW-1:0]          top_m;
  logic signed [VW-1:0]   up_max;
  logic [KW-1:0]          k2;
  logic [KW-1:0]          k2p1;
  logic [IW-1:0]          m;
  logic signed [63:0]     d64;
  logic signed [VW-1:0]   d_clamp;
  logic [IW-1:0]          cfg_size;

  // Memory ports.
  logic                   m_we;
  logic [KW-1:0]          m_waddr;
  logic [VW-1:0]          m_wdata;
  logic [VW-1:0]          m_rdata;
  logic                   p_we;
  logic [KW-1:0]          p_waddr;
  logic [VW-1:0]          p_wdata;
  logic                   p_re;
  logic [KW-1:0]          p_raddr;
  logic [VW-1:0]          p_rdata;

  // Child indices, split point and stack top.
  assign k2     = {k[KW-2:0], 1'b0};
  assign k2p1   = {k[KW-2:0], 1'b1};
  assign m      = IW'(((IW+1)'(s) + (IW+1)'(e)) >> 1);
  assign sp_m1  = sp - SPW'(1);
  assign top    = sp_m1[SIW-1:0];
  assign top_k  = stk_k[top];
  assign top_m  = IW'(((IW+1)'(stk_s[top]) + (IW+1)'(stk_e[top])) >> 1);
  assign up_max = (stk_left[top] > ret) ? stk_left[top] : ret;

  // Delta clamped to the value range.
  always_comb begin
    d64 = {{(64-DELTA_W){delta[DELTA_W-1]}}, delta};
    if (d64 > VMAX64) begin
      d_clamp = VMAX64[VW-1:0];
    end else if (d64 < VMIN64) begin
      d_clamp = VMIN64[VW-1:0];
    end else begin
      d_clamp = d64[VW-1:0];
    end
  end

  // Written size clamped to one through the element count.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_size = IW'(1);
    end else if (CW'(cfg_data) > CW'(NUM_ELEMENTS)) begin
      cfg_size = IW'(NUM_ELEMENTS);
    end else begin
      cfg_size = IW'(cfg_data);
    end
  end

  // Status toward the controller.
  always_comb begin
    status.is_query  = (mode_q == MODE_QUERY);
    status.disjoint  = (CW'(s) >= CW'(b_q)) || (CW'(e) <= CW'(a_q));
    status.full      = (CW'(s) >= CW'(a_q)) && (CW'(e) <= CW'(b_q));
    status.tn_child  = ((KW+1)'({k, 1'b1}) < (KW+1)'(TN));
    status.has_child = status.tn_child && (((IW+1)'(s) + (IW+1)'(1)) < (IW+1)'(e));
    status.amt_zero  = (amt == '0);
    status.sp_zero   = (sp == '0);
    status.top_phase = stk_phase[top];
    status.clr_last  = (clr_cnt == KW'(TN - 1));
    status.out_free  = !out_valid || !out_stall;
  end

  // Node maximum memory port selection.
  always_comb begin
    m_we    = 1'b0;
    m_waddr = k;
    m_wdata = sat_add(nm, amt);
    if (cmd.clr_step) begin
      m_we    = 1'b1;
      m_waddr = clr_cnt;
      m_wdata = '0;
    end else if (cmd.apply1) begin
      m_we = 1'b1;
    end else if (cmd.ret_up && (mode_q == MODE_ADD)) begin
      m_we    = 1'b1;
      m_waddr = top_k;
      m_wdata = up_max;
    end
  end

  // Pending add memory port selection.
  always_comb begin
    p_we    = 1'b0;
    p_waddr = k;
    p_wdata = '0;
    p_re    = cmd.visit_rd || cmd.apply1 || cmd.apply2;
    p_raddr = k;
    if (cmd.clr_step) begin
      p_we    = 1'b1;
      p_waddr = clr_cnt;
    end else if (cmd.apply1) begin
      p_we    = 1'b1;
      p_raddr = k2;
    end else if (cmd.apply2) begin
      p_we    = 1'b1;
      p_waddr = k2;
      p_wdata = sat_add(p_rdata, amt);
      p_raddr = k2p1;
    end else if (cmd.apply3) begin
      p_we    = 1'b1;
      p_waddr = k2p1;
      p_wdata = sat_add(p_rdata, amt);
    end
  end

  rarm_ram #(.WIDTH(VW), .DEPTH(TN)) u_max_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (cmd.visit_rd),
    .raddr (k),
    .rdata (m_rdata)
  );

  rarm_ram #(.WIDTH(VW), .DEPTH(TN)) u_pend_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // Control registers: size, clear counter, stack pointer and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= SIZE_RST;
      clr_cnt   <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        size    <= cfg_size;
        clr_cnt <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + KW'(1);
      end
      if (cmd.accept) begin
        sp <= '0;
      end else if (cmd.descend) begin
        sp <= sp + SPW'(1);
      end else if (cmd.ret_up) begin
        sp <= sp_m1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Traversal payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q <= mode;
      a_q    <= range_start;
      b_q    <= range_end;
      v_q    <= d_clamp;
      k      <= KW'(1);
      s      <= '0;
      e      <= size;
      acc    <= '0;
    end
    if (cmd.load) begin
      nm  <= m_rdata;
      amt <= p_rdata;
    end
    if (cmd.apply1) begin
      nm <= sat_add(nm, amt);
    end
    if (cmd.amt_v) begin
      amt <= v_q;
    end
    if (cmd.acc_upd && (nm > acc)) begin
      acc <= nm;
    end
    if (cmd.ret_nm) begin
      ret <= nm;
    end
    if (cmd.ret_zero) begin
      ret <= '0;
    end
    if (cmd.ret_up) begin
      ret <= up_max;
    end
    if (cmd.descend) begin
      k <= k2;
      e <= m;
    end
    if (cmd.ret_right) begin
      k <= {top_k[KW-2:0], 1'b1};
      s <= top_m;
      e <= stk_e[top];
    end
    if (cmd.emit) begin
      range_max <= (mode_q == MODE_QUERY) ? OUT_W'($unsigned(acc)) : '0;
    end
  end

  // Stack writes: push a parent frame, or mark the top frame for its right child.
  always_ff @(posedge clk) begin
    if (cmd.descend) begin
      stk_k[sp[SIW-1:0]]     <= k;
      stk_s[sp[SIW-1:0]]     <= s;
      stk_e[sp[SIW-1:0]]     <= e;
      stk_phase[sp[SIW-1:0]] <= PHASE_LEFT;
    end else if (cmd.ret_right) begin
      stk_phase[top] <= PHASE_RIGHT;
      stk_left[top]  <= ret;
    end
  end

endmodule
`default_nettype wire

// ===== src/range_add_range_max_tree_unit.sv =====
// Top level of the range-add, range-maximum lazy segment tree unit.
//
//   Channel | Direction | Handshake            | Payload
//   in      | input     | in_valid / in_stall  | mode, range_start, range_end, delta
//   out     | output    | out_valid / out_stall| range_max
//   cfg     | input     | cfg_valid / cfg_ready| cfg_data (active_size)
//
// One request is walked at a time. At a visited node a query leaves a node outside
// its range straight for the return state; other nodes take a read, a push of the
// pending add into both children over the APPLY1, APPLY2 and APPLY3 states, a
// second push of the delta where an update covers the node, and a return state.
// After reset and after every size write a clearing pass over all 4 * NUM_ELEMENTS
// nodes zeroes both node memories; requests are held off during it.
// A finished result waits in the output register while out_stall is high.
`default_nettype none
module range_add_range_max_tree_unit #(
  parameter int NUM_ELEMENTS = rarm_pkg::NUM_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = rarm_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                mode,
  input  wire logic [rarm_pkg::IDX_W-1:0]          range_start,
  input  wire logic [rarm_pkg::IDX_W-1:0]          range_end,
  input  wire logic signed [rarm_pkg::DELTA_W-1:0] delta,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [rarm_pkg::OUT_W-1:0]               range_max,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rarm_pkg::IDX_W-1:0]          cfg_data
);
  import rarm_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign in_stall  = !cmd.in_ready;
  assign cfg_ready = cmd.cfg_ready;

  rarm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .status    (status),
    .cmd       (cmd)
  );

  rarm_dp #(
    .NUM_ELEMENTS (NUM_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .range_start (range_start),
    .range_end   (range_end),
    .delta       (delta),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .range_max   (range_max)
  );

`ifndef ASSERT_OFF
  // A result is never loaded over one that is still stalled.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  // An accepted request closes the input until its walk is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted during a walk");

  // A size write starts a clearing pass that holds off requests.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> in_stall)
    else $error("request port open right after a size write");
`endif

endmodule
`default_nettype wire
